/* design/lla_pkg.sv */
// shared types and codes for the least-loaded bin allocator
`timescale 1ns / 1ps

package lla_pkg;

  // operation codes carried in the input tuser
  typedef enum logic [2:0] {
    FN_ALLOC  = 3'd0,
    FN_COMMIT = 3'd1,
    FN_DELETE = 3'd2,
    FN_CLEAR  = 3'd3,
    FN_INIT   = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_RANGE    = 2'd1,
    STAT_NO_BINS  = 2'd2,
    STAT_DISABLED = 2'd3
  } status_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_ENABLED   = 2'd0,
    CFG_MAX_BINS  = 2'd1,
    CFG_GROW_STEP = 2'd2,
    CFG_BIN_LIMIT = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_CHECK,
    ST_GROW,
    ST_RMW,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        enabled;
    logic [6:0]  max_bins;
    logic [6:0]  grow_step;
    logic [15:0] bin_limit;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic [6:0]  active_bins;
    logic [15:0] chosen_load;
    logic [6:0]  chosen_bin;
  } res_t;

endpackage

/* design/lla_mem.sv */
// bin load memory, one write port and one registered read port
`timescale 1ns / 1ps

module lla_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/lla_alu.sv */
// shared compare and saturating update unit for the bin loads
`timescale 1ns / 1ps

module lla_alu #(
  parameter int LOAD_WIDTH = 16
) (
  input  logic [LOAD_WIDTH-1:0] rd_data,
  input  logic [LOAD_WIDTH-1:0] best_val,
  input  logic [15:0]           bin_limit,
  input  logic                  dec,
  output logic                  lt,
  output logic                  ge_limit,
  output logic [LOAD_WIDTH-1:0] upd
);

  localparam int CMP_W = (LOAD_WIDTH > 16) ? LOAD_WIDTH : 16;

  always_comb begin
    lt       = rd_data < best_val;
    ge_limit = CMP_W'(best_val) >= CMP_W'(bin_limit);
    if (dec) begin
      upd = (rd_data == '0) ? rd_data : rd_data - LOAD_WIDTH'(1);
    end else begin
      upd = (rd_data == '1) ? rd_data : rd_data + LOAD_WIDTH'(1);
    end
  end

endmodule

/* design/lla_ctrl.sv */
// sequencer: scan, grow and read-modify-write over the load memory
`timescale 1ns / 1ps

module lla_ctrl #(
  parameter int TABLE_DEPTH = 64,
  parameter int LOAD_WIDTH  = 16,
  parameter int IDX_W       = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_func,
  input  logic [6:0]            in_num,
  input  lla_pkg::cfg_t         cfg,
  input  logic                  out_free,
  output logic                  done,
  output lla_pkg::res_t         res,
  output logic                  rd_en,
  output logic [IDX_W-1:0]      rd_addr,
  input  logic [LOAD_WIDTH-1:0] rd_data,
  output logic                  wr_en,
  output logic [IDX_W-1:0]      wr_addr,
  output logic [LOAD_WIDTH-1:0] wr_data
);

  import lla_pkg::*;

  localparam int DEPTH_CAP = (TABLE_DEPTH < 127) ? TABLE_DEPTH : 127;

  state_t state_r, state_nxt;
  logic [2:0] func_r, func_nxt;
  logic [6:0] num_r, num_nxt;
  logic [6:0] total_r, total_nxt;
  logic [6:0] scan_r, scan_nxt;
  logic [6:0] grow_end_r, grow_end_nxt;
  logic [6:0] best_idx_r, best_idx_nxt;
  logic [LOAD_WIDTH-1:0] best_val_r, best_val_nxt;
  logic [6:0] chosen_r, chosen_nxt;
  logic [LOAD_WIDTH-1:0] load_r, load_nxt;
  status_t status_r, status_nxt;

  logic [6:0] cap;
  logic [7:0] target;
  logic       grow_ok;
  logic       range_bad;
  logic [6:0] data_idx;
  logic       grow_last;
  logic [6:0] rd_idx;
  logic       lt, ge_limit;
  logic [LOAD_WIDTH-1:0] upd;

  assign cap       = (cfg.max_bins < 7'(DEPTH_CAP)) ? cfg.max_bins : 7'(DEPTH_CAP);
  assign target    = {1'b0, total_r} + {1'b0, cfg.grow_step};
  // a zero step changes nothing, so it is handled as no growth
  assign grow_ok   = (cfg.grow_step != 7'd0) && (target <= {1'b0, cap});
  assign range_bad = (num_r == 7'd0) || (num_r > total_r);
  assign data_idx  = scan_r - 7'd1;
  assign grow_last = (scan_r + 7'd1) == grow_end_r;

  lla_alu #(.LOAD_WIDTH(LOAD_WIDTH)) u_alu (
    .rd_data  (rd_data),
    .best_val (best_val_r),
    .bin_limit(cfg.bin_limit),
    .dec      (func_r == FN_DELETE),
    .lt       (lt),
    .ge_limit (ge_limit),
    .upd      (upd)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (!cfg.enabled) begin
          state_nxt = ST_DONE;
        end else begin
          unique case (func_r)
            FN_ALLOC:  state_nxt = (total_r == 7'd0) ? ST_DONE : ST_SCAN;
            FN_COMMIT,
            FN_DELETE: state_nxt = range_bad ? ST_DONE : ST_RMW;
            FN_INIT:   state_nxt = grow_ok ? ST_GROW : ST_DONE;
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_r == total_r) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = (ge_limit && grow_ok) ? ST_GROW : ST_DONE;
      end
      ST_GROW: begin
        if (grow_last) state_nxt = ST_DONE;
      end
      ST_RMW: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // handshake and memory port controls
  always_comb begin
    in_ready = 1'b0;
    done     = 1'b0;
    rd_en    = 1'b0;
    rd_idx   = 7'd0;
    wr_en    = 1'b0;
    wr_addr  = IDX_W'(scan_r);
    wr_data  = '0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_DISPATCH: begin
        if (func_r == FN_ALLOC) begin
          rd_en = 1'b1;
        end else begin
          rd_en  = (func_r == FN_COMMIT) || (func_r == FN_DELETE);
          rd_idx = num_r - 7'd1;
        end
      end
      ST_SCAN: begin
        rd_en  = scan_r != total_r;
        rd_idx = scan_r;
      end
      ST_GROW: wr_en = 1'b1;
      ST_RMW: begin
        wr_en   = 1'b1;
        wr_addr = IDX_W'(num_r - 7'd1);
        wr_data = upd;
      end
      ST_DONE: done = out_free;
      default: ;
    endcase
  end

  assign rd_addr = IDX_W'(rd_idx);

  always_comb begin
    func_nxt     = func_r;
    num_nxt      = num_r;
    total_nxt    = total_r;
    scan_nxt     = scan_r;
    grow_end_nxt = grow_end_r;
    best_idx_nxt = best_idx_r;
    best_val_nxt = best_val_r;
    chosen_nxt   = chosen_r;
    load_nxt     = load_r;
    status_nxt   = status_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          func_nxt = in_func;
          num_nxt  = in_num;
        end
      end
      ST_DISPATCH: begin
        chosen_nxt = 7'd0;
        load_nxt   = '0;
        status_nxt = STAT_OK;
        if (!cfg.enabled) begin
          status_nxt = STAT_DISABLED;
        end else begin
          unique case (func_r)
            FN_ALLOC: begin
              if (total_r == 7'd0) status_nxt = STAT_NO_BINS;
              else scan_nxt = 7'd1;
            end
            FN_COMMIT,
            FN_DELETE: begin
              if (range_bad) status_nxt = STAT_RANGE;
            end
            FN_CLEAR: total_nxt = 7'd0;
            FN_INIT: begin
              scan_nxt     = total_r;
              grow_end_nxt = target[6:0];
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // first data seeds the minimum, strict less keeps the lowest index on ties
        if (data_idx == 7'd0 || lt) begin
          best_idx_nxt = data_idx;
          best_val_nxt = rd_data;
        end
        if (scan_r != total_r) scan_nxt = scan_r + 7'd1;
      end
      ST_CHECK: begin
        if (ge_limit && grow_ok) begin
          scan_nxt     = total_r;
          grow_end_nxt = target[6:0];
        end else begin
          chosen_nxt = best_idx_r + 7'd1;
          load_nxt   = best_val_r;
        end
      end
      ST_GROW: begin
        scan_nxt = scan_r + 7'd1;
        if (grow_last) begin
          total_nxt = grow_end_r;
          // new bins are empty: the old minimum wins only if it is empty too
          if (func_r == FN_ALLOC) begin
            chosen_nxt = (best_val_r == '0) ? best_idx_r + 7'd1 : total_r + 7'd1;
            load_nxt   = '0;
          end
        end
      end
      ST_RMW: load_nxt = upd;
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      total_r <= 7'd0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    num_r      <= num_nxt;
    scan_r     <= scan_nxt;
    grow_end_r <= grow_end_nxt;
    best_idx_r <= best_idx_nxt;
    best_val_r <= best_val_nxt;
    chosen_r   <= chosen_nxt;
    load_r     <= load_nxt;
    status_r   <= status_nxt;
  end

  assign res.status      = status_r;
  assign res.active_bins = total_r;
  assign res.chosen_load = 16'(load_r);
  assign res.chosen_bin  = chosen_r;

endmodule

/* design/least_loaded_bin_allocator_core.sv */
// least-loaded bin allocator: config registers, output register, sequencer and memory
`timescale 1ns / 1ps
//
// Keeps one occupancy counter per bin and a count of active bins.
// Input transaction: in_tuser carries the operation (allocate, commit,
// delete, clear, init grow), in_tdata the 1-based bin number for commit
// and delete. Each input gives exactly one output transaction with the
// chosen bin, its load, the active bin count and a status code.
// Configuration must be written through cfg_we / cfg_addr / cfg_wdata only
// while the block is idle; the block does not enforce this. Registers written
// while idle take effect on the next operation. An allocate scans the active
// bins, reading one counter per cycle through the single memory read port
// and one compare unit, and may then grow the table.
// Commit and delete read the counter, then update it and write it back.
// The sequencer returns to idle before the next transaction is taken;
// in_tready is high only while idle.
// A finished result waits in the output register while the receiver stalls,
// and a new operation can be accepted meanwhile; it completes once the
// register has been emptied.
// Reset clears the bin count and restores the register defaults; no memory
// clearing pass is needed since grown bins are zeroed as they are added.
//
module least_loaded_bin_allocator_core #(
  parameter int TABLE_DEPTH = 64,
  parameter int LOAD_WIDTH  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [6:0] bin_number
  input  logic [2:0]  in_tuser,   // [2:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [6:0] chosen_bin, [22:7] chosen_load, [29:23] active_bins
  output logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  import lla_pkg::*;

  localparam int IDX_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int DEPTH_CAP = (TABLE_DEPTH < 127) ? TABLE_DEPTH : 127;

  cfg_t cfg_r;
  logic out_valid_r;
  res_t out_res_r;

  logic out_free;
  logic done;
  res_t res;
  logic                  rd_en, wr_en;
  logic [IDX_W-1:0]      rd_addr, wr_addr;
  logic [LOAD_WIDTH-1:0] rd_data, wr_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled   <= 1'b1;
      cfg_r.max_bins  <= 7'd64;
      cfg_r.grow_step <= 7'd4;
      cfg_r.bin_limit <= 16'd255;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ENABLED:   cfg_r.enabled   <= cfg_wdata[0];
        CFG_MAX_BINS:  cfg_r.max_bins  <= cfg_wdata[6:0];
        CFG_GROW_STEP: cfg_r.grow_step <= cfg_wdata[6:0];
        CFG_BIN_LIMIT: cfg_r.bin_limit <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_res_r <= res;
    end
  end

  lla_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .LOAD_WIDTH (LOAD_WIDTH),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .in_func (in_tuser),
    .in_num  (in_tdata[6:0]),
    .cfg     (cfg_r),
    .out_free(out_free),
    .done    (done),
    .res     (res),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  lla_mem #(
    .DEPTH(TABLE_DEPTH),
    .WIDTH(LOAD_WIDTH),
    .AW   (IDX_W)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.active_bins, out_res_r.chosen_load,
                       out_res_r.chosen_bin};
  assign out_tuser  = out_res_r.status;

  // the table never grows past the storage depth
  a_active_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_res_r.active_bins <= 7'(DEPTH_CAP)))
    else $error("active bin count beyond table depth");

  // a disabled operation reports no bin and no load
  a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res_r.status == STAT_DISABLED) |->
      (out_res_r.chosen_bin == 7'd0 && out_res_r.chosen_load == 16'd0))
    else $error("disabled result carries data");

  // a chosen bin is always an active one and only comes with ok status
  a_chosen_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res_r.chosen_bin != 7'd0) |->
      (out_res_r.chosen_bin <= out_res_r.active_bins && out_res_r.status == STAT_OK))
    else $error("chosen bin outside active range");

  // the sequencer goes busy right after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("ready while an operation is in flight");

endmodule
